>>> hdl/sfom_pkg.sv
// ----------------------------------------------------------------------------
// sfom_pkg
// Shared types and constants of the striped file to object mapper: field
// widths, register indexes, status codes and the iterative unit's control.
// ----------------------------------------------------------------------------
package sfom_pkg;

    // Field widths
    localparam int REQ_OFF_W  = 48;              // request_offset
    localparam int LEN_W      = 32;              // request_length, piece fields
    localparam int SU_W       = 32;              // stripe_unit, object_bytes
    localparam int CNT_W      = 16;              // stripe_width_count
    localparam int OBJ_W      = 48;              // object_number
    localparam int ST_W       = 2;               // status

    // Running file position: request offset plus up to one full length
    localparam int CUR_W      = REQ_OFF_W + 1;

    // Piece limit per request
    localparam int MAX_PIECES = 64;
    localparam int PC_W       = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;

    // Iterative unit step counts
    localparam int DIV_STEPS  = CUR_W;
    localparam int MUL_STEPS  = SU_W;
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);

    // Stream payload widths (whole bytes)
    localparam int IN_TDATA_W  = ((REQ_OFF_W + LEN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OBJ_W + 3 * LEN_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_UNIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_BYTES = 2'd2;

    // Register reset values
    localparam logic [SU_W-1:0]  RST_STRIPE_UNIT  = 32'd65536;
    localparam logic [CNT_W-1:0] RST_STRIPE_COUNT = 16'd1;
    localparam logic [SU_W-1:0]  RST_OBJECT_BYTES = 32'd4194304;

    // Piece status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_TRUNC = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    // Iterative unit operation
    typedef enum logic {
        OP_DIV = 1'b0,
        OP_MUL = 1'b1
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_rsp;

endpackage

>>> hdl/striped_file_to_object_mapper.sv
// ----------------------------------------------------------------------------
// striped_file_to_object_mapper
// Splits a file request at stripe-unit boundaries and maps each piece to an
// object number and object offset under a round-robin striped layout.
//
// Usage: write stripe_unit, stripe_width_count and object_bytes on the
// configuration port while the block is idle. A request transaction on the
// s_axis channel carries offset and length; the m_axis channel returns one
// transaction per piece in file order, tlast on the final one, tuser status.
// Sequencing: all arithmetic runs on one bit-serial divide/multiply unit. A
// request first divides object_bytes by stripe_unit; each piece then needs
// three divisions, two multiply-adds and an emit state, and the next piece
// starts only once the last one is moved to the output register. A bad
// layout skips the arithmetic and goes straight to the emit state.
// s_axis_tready is high only between requests. The last piece sits in an
// output register, so the next request may be taken while it waits. When
// the receiver stalls, the sequencer holds its next piece until the output
// register frees. Reset (synchronous, active low) drops any request in
// flight, clears the output valid and restores the register defaults.
// ----------------------------------------------------------------------------
module striped_file_to_object_mapper (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic [sfom_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sfom_pkg::SU_W-1:0]        i_cfg_wdata,
    // Request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: request_offset[47:0], request_length[79:48]
    input  logic [sfom_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // Piece stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: object_number[47:0], object_offset[79:48],
    //        piece_length[111:80], buffer_offset[143:112]
    output logic [sfom_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast,   // last_piece
    // tuser: status[1:0]
    output logic [sfom_pkg::ST_W-1:0]        m_axis_tuser
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PER  = 8'b0000_0010,
        S_BLK  = 8'b0000_0100,
        S_STR  = 8'b0000_1000,
        S_SET  = 8'b0001_0000,
        S_OBJ  = 8'b0010_0000,
        S_OFF  = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_start, n_start;
    logic [sfom_pkg::SU_W-1:0]       r_su, n_su;
    logic [sfom_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [sfom_pkg::SU_W-1:0]       r_ob, n_ob;

    logic [sfom_pkg::CUR_W-1:0]      r_cur, n_cur;
    logic [sfom_pkg::LEN_W-1:0]      r_left, n_left;
    logic [sfom_pkg::LEN_W-1:0]      r_buf, n_buf;
    logic [sfom_pkg::PC_W-1:0]       r_npc, n_npc;
    logic                            r_bad, n_bad;
    logic [sfom_pkg::SU_W-1:0]       r_per, n_per;
    logic [sfom_pkg::SU_W-1:0]       r_boff, n_boff;
    logic [sfom_pkg::SU_W-1:0]       r_room, n_room;
    logic [sfom_pkg::CNT_W-1:0]      r_pos, n_pos;
    logic [sfom_pkg::SU_W-1:0]       r_srem, n_srem;
    logic [sfom_pkg::OBJ_W-1:0]      r_objno, n_objno;
    logic [sfom_pkg::LEN_W-1:0]      r_objoff, n_objoff;
    logic [sfom_pkg::LEN_W-1:0]      r_plen, n_plen;

    logic                            r_ovalid, n_ovalid;
    logic [sfom_pkg::OBJ_W-1:0]      r_o_objno, n_o_objno;
    logic [sfom_pkg::LEN_W-1:0]      r_o_objoff, n_o_objoff;
    logic [sfom_pkg::LEN_W-1:0]      r_o_plen, n_o_plen;
    logic [sfom_pkg::LEN_W-1:0]      r_o_boff, n_o_boff;
    logic                            r_o_last, n_o_last;
    sfom_pkg::t_status               r_o_st, n_o_st;

    sfom_pkg::t_unit_req             u_req;
    sfom_pkg::t_unit_rsp             u_rsp;
    logic [sfom_pkg::CUR_W-1:0]      u_x, u_z;
    logic [sfom_pkg::SU_W-1:0]       u_y;
    logic [sfom_pkg::CUR_W-1:0]      u_quot, u_prod;
    logic [sfom_pkg::SU_W-1:0]       u_rem;

    logic                            in_acc;
    logic                            out_free;
    logic                            p_done, p_trunc, p_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;

    // Piece end conditions
    assign p_done  = (r_left == r_plen);
    assign p_trunc = !p_done && (r_npc == sfom_pkg::PC_W'(sfom_pkg::MAX_PIECES - 1));
    assign p_last  = r_bad || p_done || p_trunc;

    // Operand selection for the shared unit
    always_comb begin
        u_req.start = r_start;
        u_req.op    = sfom_pkg::OP_DIV;
        u_x         = u_quot;
        u_y         = r_su;
        u_z         = '0;
        case (r_state)
            S_PER: begin
                u_x = {{(sfom_pkg::CUR_W-sfom_pkg::SU_W){1'b0}}, r_ob};
            end
            S_BLK: begin
                u_x = r_cur;
            end
            S_STR: begin
                u_y = {{(sfom_pkg::SU_W-sfom_pkg::CNT_W){1'b0}}, r_cnt};
            end
            S_SET: begin
                u_y = r_per;
            end
            S_OBJ: begin
                u_req.op = sfom_pkg::OP_MUL;
                u_y = {{(sfom_pkg::SU_W-sfom_pkg::CNT_W){1'b0}}, r_cnt};
                u_z = {{(sfom_pkg::CUR_W-sfom_pkg::CNT_W){1'b0}}, r_pos};
            end
            S_OFF: begin
                u_req.op = sfom_pkg::OP_MUL;
                u_x = {{(sfom_pkg::CUR_W-sfom_pkg::SU_W){1'b0}}, r_srem};
                u_z = {{(sfom_pkg::CUR_W-sfom_pkg::SU_W){1'b0}}, r_boff};
            end
            default: begin
                u_req.start = 1'b0;
            end
        endcase
    end

    sfom_iter_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .i_x     (u_x),
        .i_y     (u_y),
        .i_z     (u_z),
        .o_rsp   (u_rsp),
        .o_quot  (u_quot),
        .o_rem   (u_rem),
        .o_prod  (u_prod)
    );

    // Sequencer, configuration and output register
    always_comb begin
        n_state    = r_state;
        n_start    = 1'b0;
        n_su       = r_su;
        n_cnt      = r_cnt;
        n_ob       = r_ob;
        n_cur      = r_cur;
        n_left     = r_left;
        n_buf      = r_buf;
        n_npc      = r_npc;
        n_bad      = r_bad;
        n_per      = r_per;
        n_boff     = r_boff;
        n_room     = r_room;
        n_pos      = r_pos;
        n_srem     = r_srem;
        n_objno    = r_objno;
        n_objoff   = r_objoff;
        n_plen     = r_plen;
        n_ovalid   = r_ovalid && !m_axis_tready;
        n_o_objno  = r_o_objno;
        n_o_objoff = r_o_objoff;
        n_o_plen   = r_o_plen;
        n_o_boff   = r_o_boff;
        n_o_last   = r_o_last;
        n_o_st     = r_o_st;

        // register writes
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sfom_pkg::CFG_STRIPE_UNIT:  n_su  = i_cfg_wdata;
                sfom_pkg::CFG_STRIPE_COUNT: n_cnt = i_cfg_wdata[sfom_pkg::CNT_W-1:0];
                sfom_pkg::CFG_OBJECT_BYTES: n_ob  = i_cfg_wdata;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cur  = {1'b0, s_axis_tdata[sfom_pkg::REQ_OFF_W-1:0]};
                    n_left = s_axis_tdata[sfom_pkg::REQ_OFF_W +: sfom_pkg::LEN_W];
                    n_buf  = '0;
                    n_npc  = '0;
                    n_bad  = (r_su == '0) || (r_cnt == '0) || (r_ob < r_su);
                    if (n_bad) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_PER;
                        n_start = 1'b1;
                    end
                end
            end
            S_PER: begin
                if (u_rsp.done) begin
                    n_per   = u_quot[sfom_pkg::SU_W-1:0];
                    n_state = S_BLK;
                    n_start = 1'b1;
                end
            end
            S_BLK: begin
                if (u_rsp.done) begin
                    n_boff  = u_rem;
                    n_room  = r_su - u_rem;
                    n_state = S_STR;
                    n_start = 1'b1;
                end
            end
            S_STR: begin
                if (u_rsp.done) begin
                    n_pos   = u_rem[sfom_pkg::CNT_W-1:0];
                    n_state = S_SET;
                    n_start = 1'b1;
                end
            end
            S_SET: begin
                if (u_rsp.done) begin
                    n_srem  = u_rem;
                    n_state = S_OBJ;
                    n_start = 1'b1;
                end
            end
            S_OBJ: begin
                if (u_rsp.done) begin
                    n_objno = u_prod[sfom_pkg::OBJ_W-1:0];
                    n_state = S_OFF;
                    n_start = 1'b1;
                end
            end
            S_OFF: begin
                if (u_rsp.done) begin
                    n_objoff = u_prod[sfom_pkg::LEN_W-1:0];
                    n_plen   = (r_left > r_room) ? r_room : r_left;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_o_last = p_last;
                    if (r_bad) begin
                        n_o_objno  = '0;
                        n_o_objoff = '0;
                        n_o_plen   = '0;
                        n_o_boff   = '0;
                        n_o_st     = sfom_pkg::ST_BAD;
                    end else begin
                        n_o_objno  = r_objno;
                        n_o_objoff = r_objoff;
                        n_o_plen   = r_plen;
                        n_o_boff   = r_buf;
                        n_o_st     = p_trunc ? sfom_pkg::ST_TRUNC : sfom_pkg::ST_OK;
                    end
                    if (p_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cur   = r_cur + {{(sfom_pkg::CUR_W-sfom_pkg::LEN_W){1'b0}}, r_plen};
                        n_left  = r_left - r_plen;
                        n_buf   = r_buf + r_plen;
                        n_npc   = r_npc + 1'b1;
                        n_state = S_BLK;
                        n_start = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
            r_su     <= sfom_pkg::RST_STRIPE_UNIT;
            r_cnt    <= sfom_pkg::RST_STRIPE_COUNT;
            r_ob     <= sfom_pkg::RST_OBJECT_BYTES;
        end else begin
            r_state  <= n_state;
            r_start  <= n_start;
            r_ovalid <= n_ovalid;
            r_su     <= n_su;
            r_cnt    <= n_cnt;
            r_ob     <= n_ob;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_left     <= n_left;
        r_buf      <= n_buf;
        r_npc      <= n_npc;
        r_bad      <= n_bad;
        r_per      <= n_per;
        r_boff     <= n_boff;
        r_room     <= n_room;
        r_pos      <= n_pos;
        r_srem     <= n_srem;
        r_objno    <= n_objno;
        r_objoff   <= n_objoff;
        r_plen     <= n_plen;
        r_o_objno  <= n_o_objno;
        r_o_objoff <= n_o_objoff;
        r_o_plen   <= n_o_plen;
        r_o_boff   <= n_o_boff;
        r_o_last   <= n_o_last;
        r_o_st     <= n_o_st;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_o_boff, r_o_plen, r_o_objoff, r_o_objno};
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_st;

    // Checks
    a_start_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> !u_rsp.busy)
        else $error("shared unit started while busy");

    a_done_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_rsp.done |-> (r_state != S_IDLE) && (r_state != S_EMIT))
        else $error("unit result arrived outside a compute state");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("second request taken while one is in flight");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_o_st != sfom_pkg::ST_OK) |-> m_axis_tlast)
        else $error("error status on a piece that is not last");

    a_piece_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_o_st != sfom_pkg::ST_BAD) |-> (r_o_plen <= r_su))
        else $error("piece longer than one stripe unit");

endmodule

>>> hdl/sfom_iter_unit.sv
// ----------------------------------------------------------------------------
// sfom_iter_unit
// Shared bit-serial arithmetic unit around one adder/subtractor.
// OP_DIV: restoring division x / y, one quotient bit per cycle.
// OP_MUL: shift-add x * y + z, one multiplier bit per cycle, mod 2^CUR_W.
// ----------------------------------------------------------------------------
module sfom_iter_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sfom_pkg::t_unit_req       i_req,
    input  logic [sfom_pkg::CUR_W-1:0] i_x,
    input  logic [sfom_pkg::SU_W-1:0]  i_y,
    input  logic [sfom_pkg::CUR_W-1:0] i_z,
    output sfom_pkg::t_unit_rsp       o_rsp,
    output logic [sfom_pkg::CUR_W-1:0] o_quot,
    output logic [sfom_pkg::SU_W-1:0]  o_rem,
    output logic [sfom_pkg::CUR_W-1:0] o_prod
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    sfom_pkg::t_op                 r_op, n_op;
    logic [sfom_pkg::STEP_W-1:0]   r_step, n_step;
    logic [sfom_pkg::CUR_W-1:0]    r_acc, n_acc;
    logic [sfom_pkg::CUR_W-1:0]    r_q, n_q;
    logic [sfom_pkg::CUR_W-1:0]    r_b, n_b;
    logic [sfom_pkg::SU_W-1:0]     r_y, n_y;

    logic [sfom_pkg::CUR_W-1:0]    opa, opb;
    logic                          sub;
    logic [sfom_pkg::CUR_W:0]      sum;
    logic                          ge;

    // Shared adder: subtract for division, add for multiplication
    always_comb begin
        sub = (r_op == sfom_pkg::OP_DIV);
        if (sub) begin
            opa = {{(sfom_pkg::CUR_W-sfom_pkg::SU_W-1){1'b0}},
                   r_acc[sfom_pkg::SU_W-1:0], r_q[sfom_pkg::CUR_W-1]};
            opb = {{(sfom_pkg::CUR_W-sfom_pkg::SU_W){1'b0}}, r_y};
        end else begin
            opa = r_acc;
            opb = r_q[0] ? r_b : '0;
        end
        sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} +
              {{sfom_pkg::CUR_W{1'b0}}, sub};
        ge  = sum[sfom_pkg::CUR_W];
    end

    // Step sequencing and operand loading
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_step = r_step;
        n_acc  = r_acc;
        n_q    = r_q;
        n_b    = r_b;
        n_y    = r_y;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_y    = i_y;
            n_b    = i_x;
            if (i_req.op == sfom_pkg::OP_DIV) begin
                n_step = sfom_pkg::STEP_W'(sfom_pkg::DIV_STEPS);
                n_acc  = '0;
                n_q    = i_x;
            end else begin
                n_step = sfom_pkg::STEP_W'(sfom_pkg::MUL_STEPS);
                n_acc  = i_z;
                n_q    = {{(sfom_pkg::CUR_W-sfom_pkg::SU_W){1'b0}}, i_y};
            end
        end else if (r_busy) begin
            if (r_op == sfom_pkg::OP_DIV) begin
                n_acc = ge ? sum[sfom_pkg::CUR_W-1:0] : opa;
                n_q   = {r_q[sfom_pkg::CUR_W-2:0], ge};
            end else begin
                n_acc = sum[sfom_pkg::CUR_W-1:0];
                n_q   = r_q >> 1;
                n_b   = r_b << 1;
            end
            n_step = r_step - 1'b1;
            if (r_step == sfom_pkg::STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_step <= n_step;
        r_acc  <= n_acc;
        r_q    <= n_q;
        r_b    <= n_b;
        r_y    <= n_y;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_quot     = r_q;
    assign o_rem      = r_acc[sfom_pkg::SU_W-1:0];
    assign o_prod     = r_acc;

endmodule

>>> tb/tb_striped_file_to_object_mapper.sv
// ----------------------------------------------------------------------------
// tb_striped_file_to_object_mapper
// Self-checking bench for the striped file to object mapper. File requests
// go in on the request stream and every piece that comes back is compared
// field by field with a local model of the round-robin striped layout.
// Directed requests cover empty, boundary-straddling, piece-limit and
// bad-layout cases. Random requests then run over a series of layouts,
// including the register extremes; both stream sides stall at random, except in the last third of the requests.
// ----------------------------------------------------------------------------
module tb_striped_file_to_object_mapper;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 5;
    localparam int SETTLE_CYCLES    = 8;     // idle guard before a register write
    localparam int DRAIN_CYCLES     = 300;   // watch for stray pieces at the end
    localparam int WATCHDOG_LIMIT   = 4000;  // cycles with no transaction
    localparam int MAX_REPORTS      = 30;
    localparam int RANDOM_LAYOUTS   = 8;
    localparam int ITEMS_PER_LAYOUT = 30;
    localparam int ITEMS_PLANNED    = 15 + RANDOM_LAYOUTS * ITEMS_PER_LAYOUT;
    localparam int IDLE_LIGHT       = 30;    // percent of cycles idle
    localparam int IDLE_HEAVY       = 81;

    // unmapped index
    localparam logic [sfom_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    localparam bit [sfom_pkg::REQ_OFF_W-1:0]   OFF_MAX       = '1;
    localparam bit [sfom_pkg::LEN_W-1:0]       LEN_MAX       = '1;

    // One piece of a mapped request
    typedef struct {
        bit [sfom_pkg::OBJ_W-1:0] obj_num;
        bit [sfom_pkg::LEN_W-1:0] obj_off;
        bit [sfom_pkg::LEN_W-1:0] plen;
        bit [sfom_pkg::LEN_W-1:0] boff;
        bit                       last;
        sfom_pkg::t_status        status;
    } t_object_piece;

    // Layout model plus the queue of pieces still owed by the block
    class piece_ledger;
        bit [sfom_pkg::SU_W-1:0]  stripe_unit;
        bit [sfom_pkg::CNT_W-1:0] width_count;
        bit [sfom_pkg::SU_W-1:0]  object_bytes;
        t_object_piece            pending_pieces[$];
        int errors;
        int requests;
        int pieces_checked;
        int truncated;
        int bad_layouts;
        int empty_requests;

        function new();
            stripe_unit  = sfom_pkg::RST_STRIPE_UNIT;
            width_count  = sfom_pkg::RST_STRIPE_COUNT;
            object_bytes = sfom_pkg::RST_OBJECT_BYTES;
        endfunction

        function void set_reg(input logic [sfom_pkg::CFG_IDX_W-1:0] idx,
                              input bit [sfom_pkg::SU_W-1:0] val);
            case (idx)
                sfom_pkg::CFG_STRIPE_UNIT:  stripe_unit  = val;
                sfom_pkg::CFG_STRIPE_COUNT: width_count  = val[sfom_pkg::CNT_W-1:0];
                sfom_pkg::CFG_OBJECT_BYTES: object_bytes = val;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_pieces.size();
        endfunction

        // Split a request at unit boundaries and queue the expected pieces
        function void map_request(input bit [sfom_pkg::REQ_OFF_W-1:0] off,
                                  input bit [sfom_pkg::LEN_W-1:0] len);
            bit [63:0] cur, left, per_obj, blockno, stripeno, stripepos, setno;
            bit [63:0] unit_off, room, plen;
            t_object_piece p;
            int n;
            bit done, trunc;
            requests++;
            if (len == 0) empty_requests++;
            if (stripe_unit == 0 || width_count == 0 || object_bytes < stripe_unit) begin
                p.obj_num = '0;
                p.obj_off = '0;
                p.plen    = '0;
                p.boff    = '0;
                p.last    = 1'b1;
                p.status  = sfom_pkg::ST_BAD;
                pending_pieces.insert(pending_pieces.size(), p);
                bad_layouts++;
                return;
            end
            per_obj = 64'(object_bytes) / 64'(stripe_unit);
            cur     = 64'(off);
            left    = 64'(len);
            n       = 0;
            trunc   = 1'b0;
            forever begin
                blockno   = cur / 64'(stripe_unit);
                stripeno  = blockno / 64'(width_count);
                stripepos = blockno % 64'(width_count);
                setno     = stripeno / per_obj;
                unit_off  = cur % 64'(stripe_unit);
                room      = 64'(stripe_unit) - unit_off;
                plen      = (left > room) ? room : left;
                done      = (left == plen);
                trunc     = !done && (n == sfom_pkg::MAX_PIECES - 1);
                p.obj_num = sfom_pkg::OBJ_W'(setno * 64'(width_count) + stripepos);
                p.obj_off = sfom_pkg::LEN_W'((stripeno % per_obj) * 64'(stripe_unit)
                                             + unit_off);
                p.plen    = sfom_pkg::LEN_W'(plen);
                p.boff    = sfom_pkg::LEN_W'(cur - 64'(off));
                p.last    = done || trunc;
                p.status  = trunc ? sfom_pkg::ST_TRUNC : sfom_pkg::ST_OK;
                pending_pieces.insert(pending_pieces.size(), p);
                if (p.last) break;
                left = left - plen;
                cur  = cur + plen;
                n++;
            end
            if (trunc) truncated++;
        endfunction

        task report_mismatch(input string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        // Compare one piece transaction with the oldest expected piece
        task check_piece(input logic [sfom_pkg::OUT_TDATA_W-1:0] data, input logic last,
                         input logic [sfom_pkg::ST_W-1:0] user);
            t_object_piece want;
            if (pending_pieces.size() == 0) begin
                report_mismatch($sformatf("piece with nothing outstanding: object %0h",
                                          data[47:0]));
                return;
            end
            want = pending_pieces.pop_front();
            pieces_checked++;
            if (data[47:0] !== want.obj_num)
                report_mismatch($sformatf("object_number got %0h exp %0h",
                                          data[47:0], want.obj_num));
            if (data[79:48] !== want.obj_off)
                report_mismatch($sformatf("object_offset got %0h exp %0h",
                                          data[79:48], want.obj_off));
            if (data[111:80] !== want.plen)
                report_mismatch($sformatf("piece_length got %0h exp %0h",
                                          data[111:80], want.plen));
            if (data[143:112] !== want.boff)
                report_mismatch($sformatf("buffer_offset got %0h exp %0h",
                                          data[143:112], want.boff));
            if (last !== want.last)
                report_mismatch($sformatf("tlast got %0b exp %0b", last, want.last));
            if (user !== want.status)
                report_mismatch($sformatf("status got %0d exp %0d", user, want.status));
        endtask
    endclass

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_wr_en   = 1'b0;
    logic [sfom_pkg::CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [sfom_pkg::SU_W-1:0]        i_cfg_wdata   = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [sfom_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [sfom_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tlast;
    logic [sfom_pkg::ST_W-1:0]        m_axis_tuser;

    piece_ledger ledger = new();
    int src_idle_pct = IDLE_LIGHT;
    int dst_idle_pct = IDLE_HEAVY;
    int items_sent   = 0;
    int layouts_run  = 0;
    int stall_cycles = 0;

    striped_file_to_object_mapper DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // request_offset, request_length
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // object_number, object_offset, piece_length, buffer_offset
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),    // last_piece
        .m_axis_tuser  (m_axis_tuser)     // status
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Piece receiver: random backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Piece checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_piece(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    // Watchdog: too long without any transaction on either stream
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, stall_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one request after a random gap; tvalid stays high after the
    // transaction, so back-to-back requests keep it asserted between them
    task automatic send_request(input bit [sfom_pkg::REQ_OFF_W-1:0] off,
                                input bit [sfom_pkg::LEN_W-1:0] len);
        int gap;
        case (items_sent * 3 / ITEMS_PLANNED)
            0: begin
                src_idle_pct = IDLE_LIGHT;
                dst_idle_pct = IDLE_HEAVY;
            end
            1: begin
                src_idle_pct = IDLE_HEAVY;
                dst_idle_pct = IDLE_LIGHT;
            end
            default: begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
        endcase
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {len, off};
        do @(posedge i_clk); while (!s_axis_tready);
        ledger.map_request(off, len);
        items_sent++;
    endtask

    // Hold off new requests until every owed piece has come back
    task automatic wait_for_pieces();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (ledger.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it
    task automatic write_reg(input logic [sfom_pkg::CFG_IDX_W-1:0] idx,
                             input bit [sfom_pkg::SU_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        ledger.set_reg(idx, val);
    endtask

    task automatic load_layout(input bit [sfom_pkg::SU_W-1:0] unit,
                               input bit [sfom_pkg::SU_W-1:0] count_word,
                               input bit [sfom_pkg::SU_W-1:0] obj);
        wait_for_pieces();
        write_reg(sfom_pkg::CFG_STRIPE_UNIT, unit);
        write_reg(sfom_pkg::CFG_STRIPE_COUNT, count_word);
        write_reg(sfom_pkg::CFG_OBJECT_BYTES, obj);
        i_cfg_wr_en <= 1'b0;
        layouts_run++;
    endtask

    initial begin
        bit [sfom_pkg::SU_W-1:0]      su_w, cnt_w, obj_w;
        bit [63:0]                    span;
        bit [sfom_pkg::REQ_OFF_W-1:0] off;
        bit [sfom_pkg::LEN_W-1:0]     len;
        int                           pick;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset layout: 64 KiB units, one object per stripe, 4 MiB objects
        send_request(48'd0, 32'd0);                        // empty request at file start
        send_request(OFF_MAX, 32'd0);                      // empty request at top offset
        send_request(48'd0, 32'd1);
        send_request(48'd65535, 32'd2);                    // straddles a unit boundary
        send_request(48'd4194303, 32'd2);                  // straddles an object boundary
        // exactly the piece limit, then one byte over: truncated
        send_request(48'd0, 32'(sfom_pkg::MAX_PIECES * 65536));
        send_request(48'd0, 32'(sfom_pkg::MAX_PIECES * 65536 + 1));
        send_request(OFF_MAX, LEN_MAX);                    // runs past the offset width

        // Write to the unmapped index must leave the layout alone
        wait_for_pieces();
        write_reg(CFG_SPARE_IDX, 32'd7);
        i_cfg_wr_en <= 1'b0;
        send_request(48'd123456, 32'd200000);

        // Three-wide stripe, object size not a multiple of the unit
        load_layout(32'd4096, 32'd3, 32'd10000);
        send_request(48'd0, 32'd28672);                    // runs into the second object set
        send_request(48'd4095, 32'd4098);

        // Bad layouts: zero unit, zero width, object smaller than a unit
        load_layout(32'd0, 32'd3, 32'd10000);
        send_request(48'd100, 32'd50);
        load_layout(32'd4096, 32'd0, 32'd10000);
        send_request(48'd100, 32'd0);
        load_layout(32'd8192, 32'd3, 32'd8191);
        send_request(48'd0, 32'd0);
        send_request(OFF_MAX, LEN_MAX);

        // Random requests over register extremes and random layouts
        for (int lay = 0; lay < RANDOM_LAYOUTS; lay++) begin
            case (lay)
                0: begin
                    su_w  = 32'd1;
                    cnt_w = 32'd65535;
                    obj_w = '1;
                end
                1: begin
                    su_w  = '1;
                    cnt_w = {16'hFFFF, 16'd1};             // upper write bits are dropped
                    obj_w = '1;
                end
                2: begin
                    su_w  = 32'd1;
                    cnt_w = 32'd1;
                    obj_w = 32'd1;
                end
                default: begin
                    pick = $urandom_range(3);
                    if (pick == 0)      su_w = $urandom_range(1, 512);
                    else if (pick == 1) su_w = 32'd1 << $urandom_range(0, 20);
                    else if (pick == 2) su_w = $urandom_range(1, 1 << 20);
                    else                su_w = $urandom;
                    if (su_w == 0) su_w = 32'd1;
                    cnt_w = {16'($urandom_range(0, 65535)),
                             ($urandom_range(3) == 0) ? 16'($urandom_range(1, 65535))
                                                      : 16'($urandom_range(1, 6))};
                    span = 64'(su_w) * 64'($urandom_range(1, 9))
                         + 64'($urandom) % 64'(su_w);
                    obj_w = (span > 64'hFFFF_FFFF) ? '1 : 32'(span);
                    if ($urandom_range(7) == 0) obj_w = su_w - 32'd1;
                end
            endcase
            load_layout(su_w, cnt_w, obj_w);

            for (int k = 0; k < ITEMS_PER_LAYOUT; k++) begin
                off  = {16'($urandom), 32'($urandom)};
                pick = $urandom_range(3);
                if (pick == 0)      off = 48'($urandom_range(0, 1 << 22));
                else if (pick == 1) off = off - off % 48'(su_w);

                span = 64'(su_w) * 3;
                if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
                pick = $urandom_range(99);
                if (pick < 6) begin
                    len = '0;
                end else if (pick < 14) begin
                    len = $urandom;                        // mostly hits the piece limit
                end else if (pick < 26) begin
                    span = 64'(su_w) * 64'($urandom_range(1, 4));
                    len  = (span > 64'hFFFF_FFFF) ? '1 : 32'(span);
                end else begin
                    len = 32'(64'($urandom) % span + 1);
                end
                send_request(off, len);
            end
        end

        wait_for_pieces();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (ledger.outstanding() != 0)
            ledger.report_mismatch($sformatf("%0d pieces never arrived", ledger.outstanding()));

        $display("Run: %0d requests over %0d layouts, %0d pieces checked",
                 ledger.requests, layouts_run, ledger.pieces_checked);
        $display("     %0d truncated, %0d bad layout, %0d empty requests, %0d mismatches",
                 ledger.truncated, ledger.bad_layouts, ledger.empty_requests, ledger.errors);
        if (ledger.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
